### design/ksc_pkg.sv
// types, codes and helpers shared by the keyword substitution cipher
`timescale 1ns / 1ps

package ksc_pkg;

	localparam int IDX_W = 5;

	typedef logic [IDX_W-1:0] idx_t;

	localparam idx_t LETTERS     = 5'd26;
	localparam idx_t FIRST_IDX   = 5'd0;
	localparam idx_t LAST_LETTER = 5'd25;

	localparam logic [2:0] MODE_CLEAR  = 3'd0;
	localparam logic [2:0] MODE_KEY    = 3'd1;
	localparam logic [2:0] MODE_FINISH = 3'd2;
	localparam logic [2:0] MODE_ENC    = 3'd3;
	localparam logic [2:0] MODE_DEC    = 3'd4;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_INVERT,
		ST_DRAIN,
		ST_LOOKUP
	} state_t;

	typedef struct packed {
		logic is_letter;
		logic lower;
		idx_t idx;
	} letter_t;

	function automatic letter_t decode_letter(input logic [7:0] b);
		letter_t r;
		r.is_letter = 1'b0;
		r.lower     = 1'b0;
		r.idx       = FIRST_IDX;
		if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
			r.is_letter = 1'b1;
			r.idx       = IDX_W'(b - CHAR_UPPER_A);
		end else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
			r.is_letter = 1'b1;
			r.lower     = 1'b1;
			r.idx       = IDX_W'(b - CHAR_LOWER_A);
		end
		return r;
	endfunction

endpackage

### design/ksc_in_if.sv
// input channel: mode and byte with valid/ready
`timescale 1ns / 1ps

interface ksc_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [7:0] byte_in;

	modport source (output valid, output mode, output byte_in, input ready);
	modport sink (input valid, input mode, input byte_in, output ready);
endinterface

### design/ksc_out_if.sv
// output channel: result byte with valid/ready
`timescale 1ns / 1ps

interface ksc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;

	modport source (output valid, output byte_out, input ready);
	modport sink (input valid, input byte_out, output ready);
endinterface

### design/keyword_substitution_cipher_core.sv
// keyword substitution cipher core: key loading, table build and byte lookup
//
// din carries a mode and a byte. mode 0 clears the key, mode 1 adds a keyword
// letter (non-letters and repeats dropped), mode 2 completes the cipher
// alphabet with the unused letters from Z down to A and rebuilds the inverse
// table, mode 3 encrypts and mode 4 decrypts one byte. only modes 3 and 4
// return a word on dout; letters keep their case, other bytes pass unchanged.
// encrypt and decrypt: the accept cycle issues the table read, and the next
// cycle, in the lookup state, uses the registered memory output and loads
// the output register once it is free; dout is valid from that register.
// finish runs through the accept cycle, the fill state placing leftover
// letters through the forward table write port, then the invert state
// reading every forward table entry, each read feeding one inverse table
// write, then the drain state for the last write.
// reset (and mode 0) marks every table entry invalid through per-entry valid
// bits; an invalid entry reads as the identity mapping, so no clearing pass.
// when dout stalls, a finished word waits in the output register; one more
// word may be accepted and is held in the lookup stage until the register
// frees up.
`timescale 1ns / 1ps

module keyword_substitution_cipher_core (
	input  logic              clk,
	input  logic              arst_n,
	ksc_in_if.sink            din,
	ksc_out_if.source         dout
);

	ksc_pkg::state_t  state_q, state_d;
	ksc_pkg::letter_t dec;

	ksc_pkg::idx_t fwd_mem [26];
	ksc_pkg::idx_t inv_mem [26];
	logic [25:0]   fwd_vld_q;
	logic [25:0]   inv_vld_q;
	logic [25:0]   used_q;
	ksc_pkg::idx_t key_len_q;
	ksc_pkg::idx_t fill_cnt_q;
	ksc_pkg::idx_t inv_cnt_q;

	// read stage
	ksc_pkg::idx_t fwd_rdata_s1;
	ksc_pkg::idx_t inv_rdata_s1;
	ksc_pkg::idx_t rd_addr_s1;
	logic          fwd_vld_s1;
	logic          inv_vld_s1;
	logic          inv_wr_s1;
	logic          letter_s1;
	logic          lower_s1;
	logic          decrypt_s1;
	logic [7:0]    byte_s1;

	logic          out_vld_q;
	logic [7:0]    out_byte_q;

	// control
	logic          fwd_we;
	ksc_pkg::idx_t fwd_wa;
	ksc_pkg::idx_t fwd_wd;
	logic          rd_en;
	ksc_pkg::idx_t rd_addr;
	logic          lookup_start;
	logic          inv_req;
	logic          key_clear;
	logic          out_load;
	logic          out_free;
	logic          accept;

	ksc_pkg::idx_t fwd_eff;
	ksc_pkg::idx_t inv_eff;
	ksc_pkg::idx_t map_idx;
	logic [7:0]    case_base;
	logic [7:0]    result_byte;

	assign dec      = ksc_pkg::decode_letter(din.byte_in);
	assign accept   = din.valid && din.ready;
	assign out_free = !out_vld_q || dout.ready;

	assign fwd_eff     = fwd_vld_s1 ? fwd_rdata_s1 : rd_addr_s1;
	assign inv_eff     = inv_vld_s1 ? inv_rdata_s1 : rd_addr_s1;
	assign map_idx     = decrypt_s1 ? inv_eff : fwd_eff;
	assign case_base   = lower_s1 ? ksc_pkg::CHAR_LOWER_A : ksc_pkg::CHAR_UPPER_A;
	assign result_byte = letter_s1 ? case_base + {3'b000, map_idx} : byte_s1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ksc_pkg::ST_IDLE: begin
				if (din.valid) begin
					if (din.mode == ksc_pkg::MODE_FINISH) begin
						state_d = ksc_pkg::ST_FILL;
					end else if (din.mode == ksc_pkg::MODE_ENC ||
					             din.mode == ksc_pkg::MODE_DEC) begin
						state_d = ksc_pkg::ST_LOOKUP;
					end
				end
			end
			ksc_pkg::ST_FILL: begin
				if (fill_cnt_q == ksc_pkg::FIRST_IDX) begin
					state_d = ksc_pkg::ST_INVERT;
				end
			end
			ksc_pkg::ST_INVERT: begin
				if (inv_cnt_q == ksc_pkg::LAST_LETTER) begin
					state_d = ksc_pkg::ST_DRAIN;
				end
			end
			ksc_pkg::ST_DRAIN: begin
				state_d = ksc_pkg::ST_IDLE;
			end
			ksc_pkg::ST_LOOKUP: begin
				if (out_free) begin
					state_d = ksc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ksc_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs of the state machine
	always_comb begin
		din.ready    = 1'b0;
		fwd_we       = 1'b0;
		fwd_wa       = key_len_q;
		fwd_wd       = dec.idx;
		rd_en        = 1'b0;
		rd_addr      = dec.idx;
		lookup_start = 1'b0;
		inv_req      = 1'b0;
		key_clear    = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			ksc_pkg::ST_IDLE: begin
				din.ready = 1'b1;
				if (din.valid) begin
					priority if (din.mode == ksc_pkg::MODE_CLEAR) begin
						key_clear = 1'b1;
					end else if (din.mode == ksc_pkg::MODE_KEY) begin
						fwd_we = dec.is_letter && !used_q[dec.idx] &&
						         (key_len_q < ksc_pkg::LETTERS);
					end else if (din.mode == ksc_pkg::MODE_ENC ||
					             din.mode == ksc_pkg::MODE_DEC) begin
						rd_en        = 1'b1;
						lookup_start = 1'b1;
					end else begin
						rd_en = 1'b0;
					end
				end
			end
			ksc_pkg::ST_FILL: begin
				fwd_wd = fill_cnt_q;
				fwd_we = !used_q[fill_cnt_q] && (key_len_q < ksc_pkg::LETTERS);
			end
			ksc_pkg::ST_INVERT: begin
				rd_en   = 1'b1;
				rd_addr = inv_cnt_q;
				inv_req = 1'b1;
			end
			ksc_pkg::ST_DRAIN: begin
				rd_en = 1'b0;
			end
			ksc_pkg::ST_LOOKUP: begin
				out_load = out_free;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ksc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// key state and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			key_len_q  <= '0;
			fwd_vld_q  <= '0;
			inv_vld_q  <= '0;
			fill_cnt_q <= ksc_pkg::LAST_LETTER;
			inv_cnt_q  <= ksc_pkg::FIRST_IDX;
			inv_wr_s1  <= 1'b0;
		end else begin
			inv_wr_s1 <= inv_req;
			if (key_clear) begin
				used_q    <= '0;
				key_len_q <= '0;
				fwd_vld_q <= '0;
				inv_vld_q <= '0;
			end else begin
				if (fwd_we) begin
					used_q[fwd_wd]    <= 1'b1;
					fwd_vld_q[fwd_wa] <= 1'b1;
					key_len_q         <= key_len_q + 5'd1;
				end
				if (inv_wr_s1) begin
					inv_vld_q[fwd_eff] <= 1'b1;
				end
			end
			if (state_q == ksc_pkg::ST_IDLE) begin
				fill_cnt_q <= ksc_pkg::LAST_LETTER;
			end else if (state_q == ksc_pkg::ST_FILL) begin
				fill_cnt_q <= fill_cnt_q - 5'd1;
			end
			if (state_q == ksc_pkg::ST_FILL) begin
				inv_cnt_q <= ksc_pkg::FIRST_IDX;
			end else if (state_q == ksc_pkg::ST_INVERT) begin
				inv_cnt_q <= inv_cnt_q + 5'd1;
			end
		end
	end

	// forward table
	always_ff @(posedge clk) begin
		if (fwd_we) begin
			fwd_mem[fwd_wa] <= fwd_wd;
		end
		if (rd_en) begin
			fwd_rdata_s1 <= fwd_mem[rd_addr];
		end
	end

	// inverse table
	always_ff @(posedge clk) begin
		if (inv_wr_s1) begin
			inv_mem[fwd_eff] <= rd_addr_s1;
		end
		if (rd_en) begin
			inv_rdata_s1 <= inv_mem[rd_addr];
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_addr_s1 <= rd_addr;
			fwd_vld_s1 <= fwd_vld_q[rd_addr];
			inv_vld_s1 <= inv_vld_q[rd_addr];
		end
		if (lookup_start) begin
			letter_s1  <= dec.is_letter;
			lower_s1   <= dec.lower;
			decrypt_s1 <= (din.mode == ksc_pkg::MODE_DEC);
			byte_s1    <= din.byte_in;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (dout.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= result_byte;
		end
	end

	assign dout.valid    = out_vld_q;
	assign dout.byte_out = out_byte_q;

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ksc_pkg::ST_IDLE) |-> !din.ready)
		else $error("word accepted while busy");

	a_used_matches_len: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == 32'(key_len_q))
		else $error("letter set and key length disagree");

	a_fill_completes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ksc_pkg::ST_FILL && fill_cnt_q == ksc_pkg::FIRST_IDX)
		|=> (key_len_q == ksc_pkg::LETTERS))
		else $error("cipher alphabet incomplete after fill");

	a_out_from_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ksc_pkg::ST_LOOKUP))
		else $error("output word without lookup");

	a_accept_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ksc_pkg::ST_INVERT && state_q != ksc_pkg::ST_DRAIN))
		else $error("accept led straight into table build");

endmodule
